// File: hdl/hrle_pkg.sv
package hrle_pkg;

  // Store geometry and scan limits
  localparam int CAPTURE_BYTES = 128;
  localparam int PATH_LIMIT    = 64;
  localparam int METHOD_MAX    = 7;
  localparam int SPACE_WINDOW  = 10;

  localparam int ADDR_W = $clog2(CAPTURE_BYTES);
  localparam int CNT_W  = $clog2(CAPTURE_BYTES + 1);
  localparam int PLEN_W = $clog2(PATH_LIMIT + 1);

  // Message classes
  localparam logic [1:0] CLS_NOT_HTTP = 2'd0;
  localparam logic [1:0] CLS_REQUEST  = 2'd1;
  localparam logic [1:0] CLS_RESPONSE = 2'd2;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PATH   = 1'b1;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Four-byte prefixes, first character in bits 7:0
  localparam logic [31:0] PFX_GET  = {" ", "T", "E", "G"};
  localparam logic [31:0] PFX_POST = {"T", "S", "O", "P"};
  localparam logic [31:0] PFX_PUT  = {" ", "T", "U", "P"};
  localparam logic [31:0] PFX_HEAD = {"D", "A", "E", "H"};
  localparam logic [31:0] PFX_DELE = {"E", "L", "E", "D"};
  localparam logic [31:0] PFX_HTTP = {"P", "T", "T", "H"};

  localparam logic [63:0] TEXT_RESPONSE = 64'h45534E4F50534552;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  msg_class;
    logic        kind;
    logic [63:0] text_bytes;
    logic [3:0]  text_len;
    logic        last_result;
  } out_item_t;

  // Request from the capture side to the walker
  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] count;
  } walk_req_t;

  // Status from the walker back to the capture side
  typedef struct packed {
    logic emit_valid;
    logic done;
  } walk_rsp_t;

endpackage

// File: hdl/http_request_line_extractor.sv
// Capture: one byte per cycle, taken while no message is being walked.
// After the last byte the walker reads the store one byte at a time, at
// most 10 header-window bytes and 64 path bytes; no byte of the next
// message is taken until the last result is loaded into the output register.
// The capture store has a single read port, used only by the walker.
// Reset (rst, synchronous) clears the byte count, walker and output valid.
module http_request_line_extractor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  hrle_pkg::in_item_t   byte_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output hrle_pkg::out_item_t  result_item
);

  logic [hrle_pkg::CNT_W-1:0]  count;
  logic                        walking;
  logic                        accept;
  logic                        room;
  logic                        emit_ready;
  logic                        rd_en;
  logic [hrle_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                  rd_data;
  hrle_pkg::walk_req_t         wreq;
  hrle_pkg::walk_rsp_t         wrsp;
  hrle_pkg::out_item_t         emit_item;

  assign byte_stall = walking;
  assign accept     = byte_valid && !walking;
  assign room       = (count < hrle_pkg::CNT_W'(hrle_pkg::CAPTURE_BYTES));
  assign emit_ready = !result_valid || !result_stall;

  assign wreq.go    = accept && byte_item.last;
  assign wreq.count = count;

  // Count captured bytes; hold during the walk, clear when it ends
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      walking <= 1'b0;
    end else begin
      if (accept) begin
        if (room) begin
          count <= count + hrle_pkg::CNT_W'(1);
        end
        if (byte_item.last) begin
          walking <= 1'b1;
        end
      end
      if (wrsp.done) begin
        count   <= '0;
        walking <= 1'b0;
      end
    end
  end

  // Writes happen only while capturing and reads only while walking,
  // so the store never sees both on one entry
  hrle_store u_store (
    .clk   (clk),
    .we    (accept && room),
    .waddr (count[hrle_pkg::ADDR_W-1:0]),
    .wdata (byte_item.data_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  hrle_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .req        (wreq),
    .rsp        (wrsp),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .emit_ready (emit_ready),
    .emit_item  (emit_item)
  );

  // Output register: load on emit, drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (wrsp.emit_valid && emit_ready) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wrsp.emit_valid && emit_ready) begin
      result_item <= emit_item;
    end
  end

endmodule

// File: hdl/hrle_store.sv
module hrle_store (
  input  logic                           clk,
  input  logic                           we,
  input  logic [hrle_pkg::ADDR_W-1:0]    waddr,
  input  logic [7:0]                     wdata,
  input  logic                           re,
  input  logic [hrle_pkg::ADDR_W-1:0]    raddr,
  output logic [7:0]                     rdata
);

  logic [7:0] mem [hrle_pkg::CAPTURE_BYTES];

  // Write captured byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/hrle_walker.sv
module hrle_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  hrle_pkg::walk_req_t          req,
  output hrle_pkg::walk_rsp_t          rsp,
  output logic                         rd_en,
  output logic [hrle_pkg::ADDR_W-1:0]  rd_addr,
  input  logic [7:0]                   rd_data,
  input  logic                         emit_ready,
  output hrle_pkg::out_item_t          emit_item
);

  typedef enum logic [2:0] {
    W_IDLE,
    W_HRD,
    W_HEV,
    W_CLASS,
    W_PRD,
    W_PEV,
    W_FIN
  } wstate_t;

  wstate_t                      state;
  logic [hrle_pkg::CNT_W-1:0]   pos;
  logic [hrle_pkg::CNT_W-1:0]   start;
  logic [31:0]                  pfx;
  logic                         got4;
  logic [55:0]                  mbuf;
  logic [2:0]                   mlen;
  logic [hrle_pkg::PLEN_W-1:0]  plen;
  logic [63:0]                  chunk;
  logic [2:0]                   clen;
  logic [63:0]                  pend_text;
  logic [3:0]                   pend_len;
  logic                         pend_kind;

  logic in_data;
  logic is_req;
  logic is_resp;
  logic is_term;
  logic emit_valid;

  // Position lies inside the captured data
  assign in_data = (pos < req.count);

  assign is_resp = got4 && (pfx == hrle_pkg::PFX_HTTP);
  assign is_req  = got4 && ((pfx == hrle_pkg::PFX_GET) || (pfx == hrle_pkg::PFX_POST) ||
                            (pfx == hrle_pkg::PFX_PUT) || (pfx == hrle_pkg::PFX_HEAD) ||
                            (pfx == hrle_pkg::PFX_DELE));

  assign is_term = (rd_data == hrle_pkg::CH_SPACE) || (rd_data == hrle_pkg::CH_QMARK) ||
                   (rd_data == hrle_pkg::CH_CR) || (rd_data == hrle_pkg::CH_LF);

  // Issue store reads from the read states
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos[hrle_pkg::ADDR_W-1:0];
    if (state == W_HRD) begin
      rd_en = in_data && (pos != hrle_pkg::CNT_W'(hrle_pkg::SPACE_WINDOW));
    end else if (state == W_PRD) begin
      rd_en = in_data && (plen != hrle_pkg::PLEN_W'(hrle_pkg::PATH_LIMIT));
    end
  end

  // Select the result to emit
  always_comb begin
    emit_valid            = 1'b0;
    emit_item.msg_class   = hrle_pkg::CLS_REQUEST;
    emit_item.kind        = pend_kind;
    emit_item.text_bytes  = pend_text;
    emit_item.text_len    = pend_len;
    emit_item.last_result = 1'b0;
    unique case (state)
      W_CLASS: begin
        if (!is_req) begin
          emit_valid            = 1'b1;
          emit_item.kind        = hrle_pkg::KIND_HEADER;
          emit_item.last_result = 1'b1;
          if (is_resp) begin
            emit_item.msg_class  = hrle_pkg::CLS_RESPONSE;
            emit_item.text_bytes = hrle_pkg::TEXT_RESPONSE;
            emit_item.text_len   = 4'd8;
          end else begin
            emit_item.msg_class  = hrle_pkg::CLS_NOT_HTTP;
            emit_item.text_bytes = '0;
            emit_item.text_len   = '0;
          end
        end
      end
      W_PEV: begin
        // A new path character proves the pending result is not the last
        emit_valid = !is_term && (clen == 3'd0);
      end
      W_FIN: begin
        emit_valid            = 1'b1;
        emit_item.last_result = 1'b1;
        if (clen != 3'd0) begin
          emit_item.kind       = hrle_pkg::KIND_PATH;
          emit_item.text_bytes = chunk;
          emit_item.text_len   = {1'b0, clen};
        end
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  assign rsp.emit_valid = emit_valid;
  assign rsp.done = emit_valid && emit_ready && emit_item.last_result;

  // Walk the stored bytes: header window, then, for a request, the path
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      unique case (state)
        W_IDLE: begin
          if (req.go) begin
            pos   <= '0;
            start <= '0;
            pfx   <= '0;
            got4  <= 1'b0;
            mbuf  <= '0;
            mlen  <= '0;
            state <= W_HRD;
          end
        end
        W_HRD: begin
          if (rd_en) begin
            state <= W_HEV;
          end else begin
            state <= W_CLASS;
          end
        end
        W_HEV: begin
          if (pos < hrle_pkg::CNT_W'(4)) begin
            pfx[pos[1:0]*8 +: 8] <= rd_data;
            if (pos == hrle_pkg::CNT_W'(3)) begin
              got4 <= 1'b1;
            end
          end
          if (rd_data == hrle_pkg::CH_SPACE) begin
            start <= pos + hrle_pkg::CNT_W'(1);
            state <= W_CLASS;
          end else begin
            if (pos < hrle_pkg::CNT_W'(hrle_pkg::METHOD_MAX)) begin
              mbuf[pos[2:0]*8 +: 8] <= rd_data;
              mlen <= pos[2:0] + 3'd1;
            end
            pos   <= pos + hrle_pkg::CNT_W'(1);
            state <= W_HRD;
          end
        end
        W_CLASS: begin
          if (is_req) begin
            pend_text <= {8'h00, mbuf};
            pend_len  <= {1'b0, mlen};
            pend_kind <= hrle_pkg::KIND_HEADER;
            pos       <= start;
            plen      <= '0;
            chunk     <= '0;
            clen      <= '0;
            state     <= W_PRD;
          end else if (emit_ready) begin
            state <= W_IDLE;
          end
        end
        W_PRD: begin
          if (rd_en) begin
            state <= W_PEV;
          end else begin
            state <= W_FIN;
          end
        end
        W_PEV: begin
          if (is_term) begin
            state <= W_FIN;
          end else if (!emit_valid || emit_ready) begin
            // Append character; a full chunk becomes the pending result
            if (clen == 3'd7) begin
              pend_text <= {rd_data, chunk[55:0]};
              pend_len  <= 4'd8;
              pend_kind <= hrle_pkg::KIND_PATH;
              chunk     <= '0;
            end else begin
              chunk[clen*8 +: 8] <= rd_data;
            end
            clen  <= clen + 3'd1;
            pos   <= pos + hrle_pkg::CNT_W'(1);
            plen  <= plen + hrle_pkg::PLEN_W'(1);
            state <= W_PRD;
          end
        end
        W_FIN: begin
          if (emit_ready) begin
            state <= W_IDLE;
          end
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/hrle_checker.sv
module hrle_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_valid,
  input logic                 byte_stall,
  input hrle_pkg::in_item_t   byte_item,
  input logic                 result_valid,
  input logic                 result_stall,
  input hrle_pkg::out_item_t  result_item
);

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // Stop taking bytes once the last byte of a message is transferred
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && byte_item.last |=> byte_stall)
    else $error("byte taken during walk");

  // Non-request results end the message
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.msg_class != hrle_pkg::CLS_REQUEST)
      |-> result_item.last_result)
    else $error("non-request result not last");

  // Path chunks belong to requests and are never empty
  a_path_chunk: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.kind == hrle_pkg::KIND_PATH)
      |-> (result_item.msg_class == hrle_pkg::CLS_REQUEST) &&
          (result_item.text_len != 4'd0) && (result_item.text_len <= 4'd8))
    else $error("bad path chunk");

  // Response header carries the full eight-character text
  a_response_text: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.msg_class == hrle_pkg::CLS_RESPONSE)
      |-> (result_item.text_len == 4'd8) &&
          (result_item.text_bytes == hrle_pkg::TEXT_RESPONSE))
    else $error("bad response result");

endmodule

bind http_request_line_extractor hrle_checker u_hrle_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_stall   (byte_stall),
  .byte_item    (byte_item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
